[rtl/core/h2r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants of the fixed-point HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned HUE_W     = 15;
  localparam int unsigned FIELD_W   = 17;
  localparam int unsigned REM_W     = 12;
  localparam int unsigned NUM_STG   = 4;

  localparam logic [FIELD_W-1:0] ONE = FIELD_W'(1) << FRAC_BITS;

  localparam logic [HUE_W-1:0] HUE_TURN   = HUE_W'(23040);
  localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(3840);

  // f = (rem << FRAC_BITS) / 3840, done as rem * RECIP >> RECIP_SH
  localparam int unsigned    RECIP_SH = 24;
  localparam longint unsigned RECIP   =
    ((64'd1 << (FRAC_BITS + RECIP_SH)) + 64'd3839) / 64'd3840;
  localparam int unsigned    RECIP_W  = $clog2(RECIP + 1);

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [FIELD_W-1:0] saturation;
    logic [FIELD_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [NUM_STG-1:0] load;
  } h2r_ctrl_t;

endpackage

[rtl/core/h2r_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_datapath
// Four register stages: hue reduction, hue fraction, saturation products,
// value products; the sector routing follows the last stage.
// ----------------------------------------------------------------------------
module h2r_datapath (
  input  logic             clk_i,
  input  h2r_pkg::h2r_ctrl_t ctrl_i,
  input  h2r_pkg::hsv_t    pixel_i,
  output h2r_pkg::rgb_t    pixel_o
);
  import h2r_pkg::*;

  localparam int unsigned PROD1_W = REM_W + RECIP_W;
  localparam int unsigned PROD2_W = 2 * FIELD_W;

  // stage 1
  logic [HUE_W-1:0]   hue_w;
  logic [HUE_W-1:0]   rem_full;
  sector_e            sec_d;
  logic [FIELD_W-1:0] sat_c, val_c;

  sector_e            sec1_q, sec2_q, sec3_q, sec4_q;
  logic               zero1_q, zero2_q, zero3_q, zero4_q;
  logic [FIELD_W-1:0] val1_q, val2_q, val3_q, val4_q;
  logic [FIELD_W-1:0] sat1_q, sat2_q;
  logic [REM_W-1:0]   rem1_q;

  // stage 2
  logic [PROD1_W-1:0]   fprod;
  logic [FRAC_BITS-1:0] frac2_q;

  // stage 3
  logic [PROD2_W-1:0] sf_prod, sg_prod;
  logic [FIELD_W-1:0] one_m_f;
  logic [FIELD_W-1:0] a3_q, b3_q, oms3_q;

  // stage 4
  logic [PROD2_W-1:0] m_prod, n_prod, k_prod;
  logic [FIELD_W-1:0] m4_q, n4_q, k4_q;

  always_comb begin
    sat_c = (pixel_i.saturation > ONE) ? ONE : pixel_i.saturation;
    val_c = (pixel_i.brightness > ONE) ? ONE : pixel_i.brightness;
    hue_w = (pixel_i.hue >= HUE_TURN) ? (pixel_i.hue - HUE_TURN) : pixel_i.hue;
    if (hue_w >= HUE_W'(5 * 3840)) begin
      sec_d    = SEC_5;
      rem_full = hue_w - HUE_W'(5 * 3840);
    end else if (hue_w >= HUE_W'(4 * 3840)) begin
      sec_d    = SEC_4;
      rem_full = hue_w - HUE_W'(4 * 3840);
    end else if (hue_w >= HUE_W'(3 * 3840)) begin
      sec_d    = SEC_3;
      rem_full = hue_w - HUE_W'(3 * 3840);
    end else if (hue_w >= HUE_W'(2 * 3840)) begin
      sec_d    = SEC_2;
      rem_full = hue_w - HUE_W'(2 * 3840);
    end else if (hue_w >= HUE_SECTOR) begin
      sec_d    = SEC_1;
      rem_full = hue_w - HUE_SECTOR;
    end else begin
      sec_d    = SEC_0;
      rem_full = hue_w;
    end
  end

  assign fprod   = PROD1_W'(rem1_q) * PROD1_W'(RECIP);
  assign one_m_f = ONE - FIELD_W'(frac2_q);
  assign sf_prod = PROD2_W'(sat2_q) * PROD2_W'(frac2_q);
  assign sg_prod = PROD2_W'(sat2_q) * PROD2_W'(one_m_f);
  assign m_prod  = PROD2_W'(val3_q) * PROD2_W'(oms3_q);
  assign n_prod  = PROD2_W'(val3_q) * PROD2_W'(a3_q);
  assign k_prod  = PROD2_W'(val3_q) * PROD2_W'(b3_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      sec1_q  <= sec_d;
      rem1_q  <= rem_full[REM_W-1:0];
      sat1_q  <= sat_c;
      val1_q  <= val_c;
      zero1_q <= (sat_c == '0);
    end
    if (ctrl_i.load[1]) begin
      sec2_q  <= sec1_q;
      frac2_q <= fprod[RECIP_SH +: FRAC_BITS];
      sat2_q  <= sat1_q;
      val2_q  <= val1_q;
      zero2_q <= zero1_q;
    end
    if (ctrl_i.load[2]) begin
      sec3_q  <= sec2_q;
      a3_q    <= ONE - sf_prod[FRAC_BITS +: FIELD_W];
      b3_q    <= ONE - sg_prod[FRAC_BITS +: FIELD_W];
      oms3_q  <= ONE - sat2_q;
      val3_q  <= val2_q;
      zero3_q <= zero2_q;
    end
    if (ctrl_i.load[3]) begin
      sec4_q  <= sec3_q;
      m4_q    <= m_prod[FRAC_BITS +: FIELD_W];
      n4_q    <= n_prod[FRAC_BITS +: FIELD_W];
      k4_q    <= k_prod[FRAC_BITS +: FIELD_W];
      val4_q  <= val3_q;
      zero4_q <= zero3_q;
    end
  end

  always_comb begin
    if (zero4_q) begin
      pixel_o = '{red: val4_q, green: val4_q, blue: val4_q};
    end else begin
      unique case (sec4_q)
        SEC_0:   pixel_o = '{red: val4_q, green: k4_q,   blue: m4_q};
        SEC_1:   pixel_o = '{red: n4_q,   green: val4_q, blue: m4_q};
        SEC_2:   pixel_o = '{red: m4_q,   green: val4_q, blue: k4_q};
        SEC_3:   pixel_o = '{red: m4_q,   green: n4_q,   blue: val4_q};
        SEC_4:   pixel_o = '{red: k4_q,   green: m4_q,   blue: val4_q};
        default: pixel_o = '{red: val4_q, green: m4_q,   blue: n4_q};
      endcase
    end
  end

endmodule

[rtl/core/hsv_to_rgb_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Fixed-point HSV to RGB pixel converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_pixel_i carries hue (1/64
//   degree, 23040 wraps to 0), saturation and brightness (65536 = 1.0).
//   Output channel out_valid_o / out_stall_i / out_pixel_o carries red,
//   green and blue (65536 = 1.0). A request moves when valid is high and
//   stall is low at a rising edge.
//   An accepted request passes the four datapath stages and then the output
//   register. Throughput: one pixel per cycle while out_stall_i is low.
//   Stage 2 holds one multiply, stage 3 two and stage 4 three.
//   Reset clears all valid bits; payload registers are not reset.
//   When the receiver stalls, the output holds and bubbles in the
//   pipeline are squeezed out; in_stall_o rises only once every stage
//   and the output register are full.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  h2r_pkg::hsv_t in_pixel_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output h2r_pkg::rgb_t out_pixel_o
);
  import h2r_pkg::*;

  logic [NUM_STG-1:0] valid_q;
  logic [NUM_STG-1:0] en;
  logic               en_out;
  logic               out_valid_q;
  rgb_t               out_pixel_q;
  rgb_t               route;
  h2r_ctrl_t          ctrl;

  always_comb begin
    en_out = !out_valid_q || !out_stall_i;
    en[NUM_STG-1] = !valid_q[NUM_STG-1] || en_out;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
    ctrl.load = en;
  end

  h2r_datapath u_datapath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .pixel_i (in_pixel_i),
    .pixel_o (route)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
      if (en_out) begin
        out_valid_q <= valid_q[NUM_STG-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_pixel_q <= route;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&valid_q)))
    else $error("input stalled while pipeline has room");

  a_drain_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NUM_STG-1] && !out_stall_i) |=> out_valid_o)
    else $error("last stage did not move to output");

  a_output_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_pixel_o.red <= ONE && out_pixel_o.green <= ONE &&
                     out_pixel_o.blue <= ONE))
    else $error("output component above full scale");

  a_idle_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !valid_q[NUM_STG-1]) |=> !out_valid_o)
    else $error("output appeared without a request in flight");
`endif

endmodule
